>>> rtl/owm_pkg.sv
package owm_pkg;

    localparam int unsigned FuncWidth  = 3;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned TpuWidth   = 8;
    localparam int unsigned SlotWidth  = 10;
    localparam int unsigned BitIdxWidth = 3;

    localparam logic [TpuWidth-1:0] TicksPerUsReset = 8'd16;

    // Command selector codes.
    localparam logic [FuncWidth-1:0] FUNC_TICK      = 3'd0;
    localparam logic [FuncWidth-1:0] FUNC_RESET     = 3'd1;
    localparam logic [FuncWidth-1:0] FUNC_WRITE     = 3'd2;
    localparam logic [FuncWidth-1:0] FUNC_READ_BYTE = 3'd3;
    localparam logic [FuncWidth-1:0] FUNC_READ_BIT  = 3'd4;

    // Slot timing in microseconds.
    localparam logic [SlotWidth-1:0] T_RESET_LOW     = 10'd480;
    localparam logic [SlotWidth-1:0] T_PRESENCE      = 10'd580;
    localparam logic [SlotWidth-1:0] T_RESET_END     = 10'd960;
    localparam logic [SlotWidth-1:0] T_START_LOW     = 10'd2;
    localparam logic [SlotWidth-1:0] T_WRITE_RELEASE = 10'd60;
    localparam logic [SlotWidth-1:0] T_READ_SAMPLE   = 10'd12;
    localparam logic [SlotWidth-1:0] T_SLOT_END      = 10'd61;

    localparam logic [BitIdxWidth-1:0] LAST_BIT = 3'd7;

    typedef enum logic [1:0] {
        PIN_RELEASED = 2'd0,
        PIN_LOW      = 2'd1,
        PIN_HIGH     = 2'd2
    } pin_t;

    typedef enum logic [4:0] {
        OP_IDLE      = 5'b00001,
        OP_RESET     = 5'b00010,
        OP_WRITE     = 5'b00100,
        OP_READ_BYTE = 5'b01000,
        OP_READ_BIT  = 5'b10000
    } op_t;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [ByteWidth-1:0] data_byte;
        logic                 bus_level;
    } owm_cmd_t;

    typedef struct packed {
        logic [1:0]           pin_mode;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [ByteWidth-1:0] read_value;
        logic                 rejected;
    } owm_result_t;

endpackage

>>> rtl/owm_ifs.sv
interface owm_cmd_if;
    import owm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FuncWidth-1:0] func;
    logic [ByteWidth-1:0] data_byte;
    logic                 bus_level;

    modport source (output valid, func, data_byte, bus_level, input ready);
    modport sink   (input valid, func, data_byte, bus_level, output ready);
endinterface

interface owm_rsp_if;
    import owm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           pin_mode;
    logic                 busy_res;
    logic                 done_res;
    logic                 presence;
    logic [ByteWidth-1:0] read_value;
    logic                 rejected;

    modport source (output valid, pin_mode, busy_res, done_res, presence, read_value,
                    rejected, input ready);
    modport sink   (input valid, pin_mode, busy_res, done_res, presence, read_value,
                    rejected, output ready);
endinterface

interface owm_cfg_if;
    import owm_pkg::*;
    logic                valid;
    logic                ready;
    logic [TpuWidth-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/one_wire_bus_master_top.sv
// One-wire bus master. Every beat on the cmd channel is one clock tick of bus
// timing: it carries a command selector (tick only, reset, write byte, read
// byte, read bit), the byte to send and the sampled bus level, and it yields
// exactly one beat on the rsp channel with the pin drive, busy, done,
// presence, the last read value and a rejected flag. The block takes one cmd
// beat per clock cycle; the result of a beat is registered and shows on rsp
// in the following cycle, and a new cmd beat is taken in that same cycle as
// long as rsp is not stalled. Bus timing is counted in microseconds, each
// microsecond being ticks_per_us cmd beats, written through the cfg channel
// (reset value 16, zero means 256). A reset sequence lasts 960 us and a bit
// slot 61 us, so a byte takes 488 us of beats; a command that arrives while
// one is running is ignored and flagged as rejected.
module one_wire_bus_master_top
    import owm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    owm_cfg_if.sink  cfg,
    owm_cmd_if.sink  cmd,
    owm_rsp_if.source rsp
);

    logic [TpuWidth-1:0] tpu_reg;
    logic                rsp_valid_reg;
    owm_result_t         rsp_reg;
    owm_result_t         core_result;
    owm_cmd_t            core_cmd;
    logic                cmd_accept;

    // The configuration register can always take a write.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TicksPerUsReset;
        end
        else if (cfg.valid)
        begin
            tpu_reg <= cfg.data;
        end
    end

    // A cmd beat is taken whenever the output register is empty or being
    // drained in this cycle, which keeps one beat per cycle under no stall.
    assign cmd.ready  = !rsp_valid_reg || rsp.ready;
    assign cmd_accept = cmd.valid && cmd.ready;

    assign core_cmd.func      = cmd.func;
    assign core_cmd.data_byte = cmd.data_byte;
    assign core_cmd.bus_level = cmd.bus_level;

    // The core holds the sequencing state and works out one tick's result.
    owm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (cmd_accept),
        .cmd          (core_cmd),
        .ticks_per_us (tpu_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // The result payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.pin_mode   = rsp_reg.pin_mode;
    assign rsp.busy_res   = rsp_reg.busy_res;
    assign rsp.done_res   = rsp_reg.done_res;
    assign rsp.presence   = rsp_reg.presence;
    assign rsp.read_value = rsp_reg.read_value;
    assign rsp.rejected   = rsp_reg.rejected;

endmodule

>>> rtl/owm_core.sv
module owm_core
    import owm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  owm_cmd_t            cmd,
    input  logic [TpuWidth-1:0] ticks_per_us,
    output owm_result_t         result
);

    op_t                    op_reg, op_next;
    logic [TpuWidth-1:0]    pre_reg, pre_next;
    logic [SlotWidth-1:0]   slot_reg, slot_next;
    logic [ByteWidth-1:0]   shift_reg, shift_next;
    logic [BitIdxWidth-1:0] bit_reg, bit_next;
    logic                   pres_reg, pres_next;
    logic [ByteWidth-1:0]   hold_reg, hold_next;

    logic                   is_cmd;
    op_t                    cmd_op;
    logic [SlotWidth-1:0]   t;
    logic                   first;
    logic                   finish;
    pin_t                   pin;
    logic                   done;
    logic                   rej;

    always_comb
    begin
        case (cmd.func)
            FUNC_RESET:     cmd_op = OP_RESET;
            FUNC_WRITE:     cmd_op = OP_WRITE;
            FUNC_READ_BYTE: cmd_op = OP_READ_BYTE;
            FUNC_READ_BIT:  cmd_op = OP_READ_BIT;
            default:        cmd_op = OP_IDLE;
        endcase
        is_cmd = (cmd_op != OP_IDLE);
    end

    always_comb
    begin
        op_next    = op_reg;
        pre_next   = pre_reg;
        slot_next  = slot_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        pres_next  = pres_reg;
        hold_next  = hold_reg;
        pin        = PIN_RELEASED;
        done       = 1'b0;
        rej        = 1'b0;
        finish     = 1'b0;
        t          = '0;
        first      = 1'b0;

        if (op_reg == OP_IDLE)
        begin
            if (is_cmd)
            begin
                op_next    = cmd_op;
                pre_next   = '0;
                slot_next  = '0;
                bit_next   = '0;
                shift_next = (cmd_op == OP_WRITE) ? cmd.data_byte : '0;
            end
        end
        else if (is_cmd)
        begin
            rej = 1'b1;
        end

        if (op_next != OP_IDLE)
        begin
            t     = slot_next;
            first = (pre_next == '0);

            if (op_next == OP_RESET)
            begin
                if (t >= T_RESET_END)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    pin = (t < T_RESET_LOW) ? PIN_LOW : PIN_RELEASED;
                    if (first && t == T_PRESENCE)
                    begin
                        pres_next = ~cmd.bus_level;
                    end
                end
            end
            else
            begin
                if (t >= T_SLOT_END)
                begin
                    if (op_next == OP_READ_BIT || bit_next == LAST_BIT)
                    begin
                        finish = 1'b1;
                        if (op_next == OP_READ_BYTE)
                        begin
                            hold_next = shift_next;
                        end
                    end
                    else
                    begin
                        // Next bit slot of the byte starts on this tick.
                        bit_next  = bit_next + 1'b1;
                        slot_next = '0;
                        pre_next  = '0;
                        t         = '0;
                        first     = 1'b1;
                    end
                end
                if (!finish)
                begin
                    if (t < T_START_LOW)
                    begin
                        pin = PIN_LOW;
                    end
                    else if (op_next == OP_WRITE)
                    begin
                        if (t < T_WRITE_RELEASE)
                        begin
                            pin = shift_next[bit_next] ? PIN_HIGH : PIN_LOW;
                        end
                        else
                        begin
                            pin = PIN_RELEASED;
                        end
                    end
                    else
                    begin
                        pin = PIN_RELEASED;
                        if (first && t == T_READ_SAMPLE)
                        begin
                            if (op_next == OP_READ_BYTE)
                            begin
                                shift_next[bit_next] = shift_next[bit_next] | cmd.bus_level;
                            end
                            else
                            begin
                                hold_next = {{(ByteWidth-1){1'b0}}, cmd.bus_level};
                            end
                        end
                    end
                end
            end

            if (finish)
            begin
                op_next   = OP_IDLE;
                pre_next  = '0;
                slot_next = '0;
                pin       = PIN_RELEASED;
                done      = 1'b1;
            end
            else if (pre_next == ticks_per_us - 1'b1)
            begin
                pre_next  = '0;
                slot_next = slot_next + 1'b1;
            end
            else
            begin
                pre_next = pre_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            pre_reg   <= '0;
            slot_reg  <= '0;
            shift_reg <= '0;
            bit_reg   <= '0;
            pres_reg  <= 1'b0;
            hold_reg  <= '0;
        end
        else if (accept)
        begin
            op_reg    <= op_next;
            pre_reg   <= pre_next;
            slot_reg  <= slot_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            pres_reg  <= pres_next;
            hold_reg  <= hold_next;
        end
    end

    always_comb
    begin
        result.pin_mode   = pin;
        result.busy_res   = (op_next != OP_IDLE);
        result.done_res   = done;
        result.presence   = pres_next;
        result.read_value = hold_next;
        result.rejected   = rej;
    end

endmodule

>>> rtl/owm_checker.sv
module owm_checker
    import owm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [1:0]           pin_mode,
    input logic                 busy_res,
    input logic                 done_res,
    input logic [ByteWidth-1:0] read_value
);

    // Every accepted tick produces a result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> rsp_valid)
        else $error("no result beat after an accepted tick");

    // No new tick is taken while a result is waiting and stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !cmd_ready)
        else $error("tick accepted while the result register is stalled");

    // A finishing tick leaves the master idle with the bus released.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && done_res) |-> (!busy_res && pin_mode == PIN_RELEASED))
        else $error("done reported while busy or driving the bus");

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(pin_mode) && $stable(read_value)))
        else $error("stalled result payload changed");

endmodule

bind one_wire_bus_master_top owm_checker u_owm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .pin_mode   (rsp.pin_mode),
    .busy_res   (rsp.busy_res),
    .done_res   (rsp.done_res),
    .read_value (rsp.read_value)
);

>>> tb/tb_one_wire_bus_master_top.sv
module tb_one_wire_bus_master_top;
    import owm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The run ends here even if the block hangs. The slowest correct run is
    // roughly 2.3k beats with their waits; this limit is well above that.
    localparam int unsigned CYCLE_LIMIT = 300_000;

    // Selector values that the block must treat as a plain tick.
    localparam int FUNC_UNUSED_FIRST = 5;
    localparam int FUNC_UNUSED_LAST  = 7;

    // Effectively no limit on how many filler ticks follow a command.
    localparam int NO_CAP = 1 << 30;

    // Mismatches beyond this many are counted but not printed.
    localparam int PRINT_CAP = 40;

    // How the sampled bus level behaves during the ticks of one operation.
    typedef enum logic [1:0] {
        LINE_LOW,
        LINE_HIGH,
        LINE_RANDOM
    } line_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    owm_cfg_if cfg();
    owm_cmd_if cmd();
    owm_rsp_if rsp();

    one_wire_bus_master_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus master model. It holds its own copy of the timing state and of
    // ticks_per_us, and is advanced once per accepted cmd beat.
    // ------------------------------------------------------------------
    op_t         ow_op;
    logic [7:0]  ow_tpu;
    logic [7:0]  ow_presc;
    logic [9:0]  ow_slot;
    logic [7:0]  ow_shift;
    logic [2:0]  ow_bit;
    logic        ow_presence;
    logic [7:0]  ow_read;

    // Expected rsp beats, oldest first, and the beats still to be driven.
    owm_result_t owed_rsp[$];
    owm_cmd_t    tick_backlog[$];

    // Beat counters. n_queued belongs to the stimulus process; the other two
    // are updated by the monitor with nonblocking assignments so that the
    // stimulus process can read them at the clock edge without a race.
    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int fails      = 0;

    // One tick of the master. Returns what the block should report for it.
    function automatic owm_result_t master_tick(input owm_cmd_t c);
        owm_result_t r;
        pin_t        pin;
        logic [9:0]  t;
        logic        first;
        logic        finish;
        logic        is_cmd;
        logic        rej;

        r      = '0;
        pin    = PIN_RELEASED;
        finish = 1'b0;
        rej    = 1'b0;
        is_cmd = (c.func >= FUNC_RESET) && (c.func <= FUNC_READ_BIT);

        // A command starts an operation only from idle; otherwise it is
        // dropped and flagged.
        if (ow_op == OP_IDLE)
        begin
            if (is_cmd)
            begin
                case (c.func)
                    FUNC_RESET:     ow_op = OP_RESET;
                    FUNC_WRITE:     ow_op = OP_WRITE;
                    FUNC_READ_BYTE: ow_op = OP_READ_BYTE;
                    default:        ow_op = OP_READ_BIT;
                endcase
                ow_presc = '0;
                ow_slot  = '0;
                ow_bit   = '0;
                ow_shift = (c.func == FUNC_WRITE) ? c.data_byte : 8'h00;
            end
        end
        else if (is_cmd)
        begin
            rej = 1'b1;
        end

        if (ow_op != OP_IDLE)
        begin
            t     = ow_slot;
            first = (ow_presc == 8'd0);

            if (ow_op == OP_RESET)
            begin
                if (t >= T_RESET_END)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    pin = (t < T_RESET_LOW) ? PIN_LOW : PIN_RELEASED;
                    // Presence is the device holding the line low at the
                    // first tick of the presence microsecond.
                    if (first && t == T_PRESENCE)
                    begin
                        ow_presence = ~c.bus_level;
                    end
                end
            end
            else
            begin
                // End of a bit slot: either the operation is over or the
                // next bit slot begins on this very tick.
                if (t >= T_SLOT_END)
                begin
                    if (ow_op == OP_READ_BIT || ow_bit == LAST_BIT)
                    begin
                        finish = 1'b1;
                        if (ow_op == OP_READ_BYTE)
                        begin
                            ow_read = ow_shift;
                        end
                    end
                    else
                    begin
                        ow_bit   = ow_bit + 3'd1;
                        ow_slot  = '0;
                        ow_presc = '0;
                        t        = '0;
                        first    = 1'b1;
                    end
                end
                if (!finish)
                begin
                    if (t < T_START_LOW)
                    begin
                        pin = PIN_LOW;
                    end
                    else if (ow_op == OP_WRITE)
                    begin
                        if (t < T_WRITE_RELEASE)
                        begin
                            pin = ow_shift[ow_bit] ? PIN_HIGH : PIN_LOW;
                        end
                        else
                        begin
                            pin = PIN_RELEASED;
                        end
                    end
                    else
                    begin
                        pin = PIN_RELEASED;
                        if (first && t == T_READ_SAMPLE)
                        begin
                            if (ow_op == OP_READ_BYTE)
                            begin
                                ow_shift[ow_bit] = ow_shift[ow_bit] | c.bus_level;
                            end
                            else
                            begin
                                ow_read = {7'd0, c.bus_level};
                            end
                        end
                    end
                end
            end

            // Prescaler. A ticks_per_us of zero makes the compare value 255,
            // so one microsecond is then 256 ticks.
            if (finish)
            begin
                ow_op     = OP_IDLE;
                ow_presc  = '0;
                ow_slot   = '0;
                pin       = PIN_RELEASED;
                r.done_res = 1'b1;
            end
            else if (ow_presc == ow_tpu - 8'd1)
            begin
                ow_presc = '0;
                ow_slot  = ow_slot + 10'd1;
            end
            else
            begin
                ow_presc = ow_presc + 8'd1;
            end
        end

        r.pin_mode   = pin;
        r.busy_res   = (ow_op != OP_IDLE);
        r.presence   = ow_presence;
        r.read_value = ow_read;
        r.rejected   = rej;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            fails++;
            if (fails <= PRINT_CAP)
            begin
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before any of the
    // block's registers update. The rsp beat is matched before the cmd beat
    // of the same edge is predicted, since that rsp belongs to an older cmd.
    // ------------------------------------------------------------------
    logic cmd_beat;
    logic rsp_beat;

    always @(posedge clk)
    begin : monitor
        owm_cmd_t    beat;
        owm_result_t want;

        if (!rst_n)
        begin
            ow_op       = OP_IDLE;
            ow_tpu      = TicksPerUsReset;
            ow_presc    = '0;
            ow_slot     = '0;
            ow_shift    = '0;
            ow_bit      = '0;
            ow_presence = 1'b0;
            ow_read     = '0;
            cmd_beat   <= 1'b0;
            rsp_beat   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                ow_tpu = cfg.data;
            end

            if (rsp.valid && rsp.ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    fails++;
                    if (fails <= PRINT_CAP)
                    begin
                        $display("%0t ns: rsp beat with none expected, got pin_mode %0d",
                                 $time, rsp.pin_mode);
                    end
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("pin_mode",   want.pin_mode,   rsp.pin_mode);
                    check_field("busy_res",   want.busy_res,   rsp.busy_res);
                    check_field("done_res",   want.done_res,   rsp.done_res);
                    check_field("presence",   want.presence,   rsp.presence);
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("rejected",   want.rejected,   rsp.rejected);
                end
                n_checked <= n_checked + 1;
            end

            if (cmd.valid && cmd.ready)
            begin
                beat.func      = cmd.func;
                beat.data_byte = cmd.data_byte;
                beat.bus_level = cmd.bus_level;
                owed_rsp.push_back(master_tick(beat));
                n_accepted <= n_accepted + 1;
            end

            cmd_beat <= cmd.valid && cmd.ready;
            rsp_beat <= rsp.valid && rsp.ready;
        end
    end

    // ------------------------------------------------------------------
    // Idle and stall pattern, shared by both sides. Most beats are followed
    // by a random wait; now and then a long calm stretch with no waiting at
    // all lets the block run at full rate.
    // ------------------------------------------------------------------
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(20, 300);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // cmd driver. Inputs change on the falling edge. A beat stays on the bus
    // until the monitor saw it taken; only then does the next one, or a gap,
    // follow.
    int cmd_gap  = 0;
    int cmd_calm = 0;

    always @(negedge clk)
    begin : drive_cmd
        owm_cmd_t beat;

        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else if (!cmd.valid || cmd_beat)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd.valid <= 1'b0;
            end
            else if (tick_backlog.size() != 0)
            begin
                beat = tick_backlog.pop_front();
                cmd.valid     <= 1'b1;
                cmd.func      <= beat.func;
                cmd.data_byte <= beat.data_byte;
                cmd.bus_level <= beat.bus_level;
                cmd_gap = draw_wait(cmd_calm);
            end
            else
            begin
                cmd.valid <= 1'b0;
            end
        end
    end

    // rsp stalls. A fresh stall length is drawn after every taken beat and
    // counts down only while a result is actually offered, so the stalls
    // always land on results.
    int rsp_gap  = 0;
    int rsp_calm = 0;

    always @(negedge clk)
    begin : drive_rsp
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp_beat)
            begin
                rsp_gap = draw_wait(rsp_calm);
            end
            if (rsp_gap > 0)
            begin
                rsp.ready <= 1'b0;
                if (rsp.valid)
                begin
                    rsp_gap--;
                end
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. gen_tpu mirrors the last value written, so the
    // stimulus knows how many ticks each operation lasts.
    // ------------------------------------------------------------------
    logic [7:0] gen_tpu = TicksPerUsReset;

    function automatic logic line_bit(input line_mode_t line);
        case (line)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom);
        endcase
    endfunction

    task automatic push_tick(input logic [2:0] func, input logic [7:0] value,
                             input logic level);
        owm_cmd_t beat;

        beat.func      = func;
        beat.data_byte = value;
        beat.bus_level = level;
        tick_backlog.push_back(beat);
        n_queued++;
    endtask

    // Ticks while an operation runs. Some carry a command, which the block
    // must reject, and some carry an unused selector.
    task automatic push_busy_ticks(input int n, input line_mode_t line);
        logic [2:0] func;

        repeat (n)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                func = 3'($urandom_range(FUNC_RESET, FUNC_READ_BIT));
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
            end
            else
            begin
                func = FUNC_TICK;
            end
            push_tick(func, 8'($urandom), line_bit(line));
        end
    endtask

    // Ticks while idle: never a real command, so no operation starts.
    task automatic push_idle_ticks(input int n);
        logic [2:0] func;

        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
            end
            else
            begin
                func = FUNC_TICK;
            end
            push_tick(func, 8'($urandom), 1'($urandom));
        end
    endtask

    // A command from idle followed by exactly the ticks it needs, so that the
    // last tick is the one that reports done. With a cap the operation is
    // cut short and left running.
    task automatic push_op(input logic [2:0] func, input logic [7:0] value,
                           input line_mode_t line, input int cap, output int pushed);
        int eff;
        int span;

        eff = (gen_tpu == 8'd0) ? 256 : int'(gen_tpu);
        if (func == FUNC_RESET)
        begin
            span = int'(T_RESET_END) * eff;
        end
        else if (func == FUNC_READ_BIT)
        begin
            span = int'(T_SLOT_END) * eff;
        end
        else
        begin
            span = int'(T_SLOT_END) * (int'(LAST_BIT) + 1) * eff;
        end
        if (span > cap)
        begin
            span = cap;
        end
        push_tick(func, value, line_bit(line));
        push_busy_ticks(span, line);
        pushed = span + 1;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (n_accepted != n_queued || n_checked != n_accepted)
        begin
            @(posedge clk);
        end
    endtask

    // Write ticks_per_us once every expected beat has come back. If an
    // operation is still running it continues at the new rate; idle ticks are
    // fed until the master is idle again.
    task automatic write_tpu(input logic [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        gen_tpu = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
        wait_drained();
        while (ow_op != OP_IDLE)
        begin
            push_idle_ticks(32);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int n;

        rst_n         = 1'b0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        cmd.valid     = 1'b0;
        cmd.func      = FUNC_TICK;
        cmd.data_byte = '0;
        cmd.bus_level = 1'b0;
        rsp.ready     = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset rate of 16 ticks per microsecond: plain
        // ticks at both data extremes, the unused selectors, then a read bit
        // with a write arriving on the very next beat, which must be rejected.
        // The read bit runs just past its sample point and is left running,
        // with the prescaler back at zero, so that the next register write
        // lands in the middle of the slot.
        push_tick(FUNC_TICK, 8'h00, 1'b0);
        push_tick(FUNC_TICK, 8'hFF, 1'b1);
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
        begin
            push_tick(3'(f), 8'hFF, 1'b1);
        end
        push_tick(FUNC_READ_BIT, 8'h00, 1'b0);
        push_tick(FUNC_WRITE, 8'hFF, 1'b0);
        push_busy_ticks((int'(T_READ_SAMPLE) + 1) * int'(TicksPerUsReset) - 2, LINE_LOW);

        // One tick per microsecond keeps whole operations short. A reset with
        // a device answering, a write with both bit values, a byte read of a
        // random line and a bit read of a line held high.
        write_tpu(8'd1);
        push_op(FUNC_RESET,     8'h00, LINE_LOW,    NO_CAP, n);
        push_op(FUNC_WRITE,     8'hA5, LINE_RANDOM, NO_CAP, n);
        push_op(FUNC_READ_BYTE, 8'h5A, LINE_RANDOM, NO_CAP, n);
        push_op(FUNC_READ_BIT,  8'h00, LINE_HIGH,   NO_CAP, n);

        // Every beat has come back; the block is then left to run on, so that
        // any result it should not produce would show.
        wait_drained();
        repeat (20) @(posedge clk);

        if (fails == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
